// ===== sv/first_fit_region_allocator_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_REGION_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_REGION_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define FFRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define FFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ffra_pkg.sv =====
// Shared constants, status codes and types of the first-fit region allocator.
package ffra_pkg;

  localparam int MAX_REGIONS  = 16;
  localparam int HEADER_BYTES = 24;
  localparam int ALIGN_BYTES  = 8;
  localparam int ADDR_W       = 52;
  localparam int CNT_W        = $clog2(MAX_REGIONS + 1);
  localparam int ALIGN_W      = $clog2(ALIGN_BYTES);

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_TYPE  = 3'd1;
  localparam logic [2:0] ST_SMALL = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_ALLOC = 3'd4;
  localparam logic [2:0] ST_NOFIT = 3'd5;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] hdr;
    logic [ADDR_W-1:0] size;
  } entry_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic capture;    // compare against the incoming request
    logic occ;        // cell holds a live region
    logic load_left;  // take left neighbour's entry (head insertion)
    logic load_right; // take right neighbour's entry (removal)
    logic take;       // this cell is the first fit of an allocation
  } cell_ctl_t;

  // Grant a cell would give if it were the first fit.
  typedef struct packed {
    logic              split;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] size;
  } grant_t;

endpackage

// ===== sv/ffra_cell.sv =====
// One region cell of the allocator chain: holds an entry and its fit compare.
module ffra_cell
  import ffra_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [ADDR_W-1:0] req_now,
  input  logic [ADDR_W-1:0] req_held,
  input  entry_t            left_entry,
  input  entry_t            right_entry,
  output entry_t            entry,
  output logic              fit,
  output grant_t            grant
);

  entry_t            entry_r;
  logic              fit_r;
  logic [ADDR_W-1:0] diff_r;
  logic              split;

  // Remainder leaves room for a fresh header.
  assign split = (diff_r >= ADDR_W'(HEADER_BYTES));

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      fit_r  <= ctl.occ && (entry_r.size >= req_now);
      diff_r <= entry_r.size - req_now;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_left) begin
      entry_r <= left_entry;
    end else if (ctl.take && split) begin
      entry_r.hdr  <= entry_r.hdr + ADDR_W'(HEADER_BYTES) + req_held;
      entry_r.size <= diff_r - ADDR_W'(HEADER_BYTES);
    end else if (ctl.load_right) begin
      entry_r <= right_entry;
    end
  end

  assign entry       = entry_r;
  assign fit         = fit_r;
  assign grant.split = split;
  assign grant.addr  = entry_r.hdr + ADDR_W'(HEADER_BYTES);
  assign grant.size  = split ? req_held : entry_r.size;

endmodule

// ===== sv/first_fit_region_allocator.sv =====
// First-fit region allocator: a row of region cells driven by a two-state sequencer.
//
// For each word, start is taken when busy is low, busy is high for the
// following evaluate cycle, and the result word is on the out_ ports for
// exactly one cycle after that, marked by out_valid. The receiver cannot
// stall, so nothing holds a result back; a new start is accepted in the same
// cycle the previous result is shown. The work is done in the cell
// row: at the start edge every cell compares its payload size against the
// request and registers the outcome and the remainder, and at the evaluate
// edge the first fitting cell is picked, the row is updated (shift right on an
// add, shift left from the hit on a removal, split in place otherwise) and the
// result word is registered. The region store has no reset: only entries
// below the region count are ever compared.
module first_fit_region_allocator
  import ffra_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_action,
  input  logic [ADDR_W-1:0] in_region_base,
  input  logic [ADDR_W-1:0] in_region_length,
  input  logic [2:0]        in_region_type,
  input  logic [ADDR_W-1:0] in_request_size,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [ADDR_W-1:0] out_address,
  output logic [ADDR_W-1:0] out_granted_size
);

  `include "first_fit_region_allocator_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // Held request word
  logic              action_r;
  logic              type_bad_r;
  logic [ADDR_W:0]   end_r;     // region end, clipped to the top of the address space
  logic [ADDR_W:0]   hdr_r;     // header address aligned up, may reach the top
  logic [ADDR_W-1:0] req_r;

  logic [CNT_W-1:0]  count_r, count_nxt;

  // Result word
  logic              out_valid_r;
  logic [2:0]        out_status_r, status_nxt;
  logic [ADDR_W-1:0] out_address_r, addr_nxt;
  logic [ADDR_W-1:0] out_granted_size_r, granted_nxt;

  // Add path, worked out from the ports at the start edge
  logic [ADDR_W:0]   end_raw, end_clip, hdr_align;

  // Evaluate cycle
  logic              too_small, full, add_ok, found, remove;
  entry_t            new_entry;
  logic [MAX_REGIONS-1:0] fit_v, first_v, after_v;
  grant_t            sel_grant;

  cell_ctl_t         ctl    [MAX_REGIONS];
  entry_t            entries[MAX_REGIONS];
  grant_t            grants [MAX_REGIONS];

  assign accept = start && !busy;
  assign busy   = (state_r == S_EVAL);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_EVAL;
      S_EVAL:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Clip the region end and align the header up to the alignment step
  always_comb begin
    end_raw   = {1'b0, in_region_base} + {1'b0, in_region_length};
    end_clip  = end_raw[ADDR_W] ? {1'b1, {ADDR_W{1'b0}}} : end_raw;
    hdr_align = ({1'b0, in_region_base} + (ADDR_W + 1)'(ALIGN_BYTES - 1))
                & ~(ADDR_W + 1)'(ALIGN_BYTES - 1);
  end

  // Hold the request word for the evaluate cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r   <= in_action;
      type_bad_r <= (in_region_type != 3'd0);
      end_r      <= end_clip;
      hdr_r      <= hdr_align;
      req_r      <= in_request_size;
    end
  end

  // Pick the first fitting cell and everything from it onward
  always_comb begin
    first_v = fit_v & (~fit_v + MAX_REGIONS'(1));
    found   = |fit_v;
    after_v = ~(first_v - MAX_REGIONS'(1)) & {MAX_REGIONS{found}};
  end

  always_comb begin
    sel_grant = '0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      if (first_v[i]) sel_grant = sel_grant | grants[i];
    end
  end

  always_comb begin
    too_small      = ((hdr_r + (ADDR_W + 1)'(HEADER_BYTES)) > end_r);
    full           = (count_r >= CNT_W'(MAX_REGIONS));
    add_ok         = busy && (action_r == ACT_ADD) && !type_bad_r && !too_small && !full;
    remove         = busy && (action_r == ACT_ALLOC) && found && !sel_grant.split;
    new_entry.hdr  = hdr_r[ADDR_W-1:0];
    new_entry.size = ADDR_W'(end_r - hdr_r - (ADDR_W + 1)'(HEADER_BYTES));
  end

  // Per-cell control
  always_comb begin
    for (int i = 0; i < MAX_REGIONS; i++) begin
      ctl[i].capture    = accept;
      ctl[i].occ        = (CNT_W'(i) < count_r);
      ctl[i].load_left  = add_ok;
      ctl[i].load_right = remove && after_v[i];
      ctl[i].take       = busy && (action_r == ACT_ALLOC) && first_v[i];
    end
  end

  // Cell row: left neighbour feeds insertion, right neighbour feeds removal
  for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
    ffra_cell u_cell (
      .clk         (clk),
      .ctl         (ctl[g]),
      .req_now     (in_request_size),
      .req_held    (req_r),
      .left_entry  ((g == 0) ? new_entry : entries[(g == 0) ? 0 : g - 1]),
      .right_entry ((g == MAX_REGIONS - 1) ? entries[g]
                    : entries[(g == MAX_REGIONS - 1) ? g : g + 1]),
      .entry       (entries[g]),
      .fit         (fit_v[g]),
      .grant       (grants[g])
    );
  end

  // Result word and region count
  always_comb begin
    status_nxt  = ST_ADDED;
    addr_nxt    = '0;
    granted_nxt = '0;
    count_nxt   = count_r;
    if (action_r == ACT_ADD) begin
      if (type_bad_r) begin
        status_nxt = ST_TYPE;
      end else if (too_small) begin
        status_nxt = ST_SMALL;
      end else if (full) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = ST_ADDED;
        count_nxt  = count_r + CNT_W'(1);
      end
    end else if (found) begin
      status_nxt  = ST_ALLOC;
      addr_nxt    = sel_grant.addr;
      granted_nxt = sel_grant.size;
      if (!sel_grant.split) count_nxt = count_r - CNT_W'(1);
    end else begin
      status_nxt = ST_NOFIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= busy;
      if (busy) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      out_status_r       <= status_nxt;
      out_address_r      <= addr_nxt;
      out_granted_size_r <= granted_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_address      = out_address_r;
  assign out_granted_size = out_granted_size_r;

  // Checks
  `FFRA_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_REGIONS), "region count overflow")
  `FFRA_ASSERT_NOW(a_out_after_eval, out_valid, $past(state_r == S_EVAL), "result without evaluate")
  `FFRA_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
  `FFRA_ASSERT_NOW(a_zero_unless_alloc, out_valid && (out_status != ST_ALLOC), (out_address == '0) && (out_granted_size == '0), "grant fields set without allocation")

endmodule

// ===== bench/tb_first_fit_region_allocator.sv =====
// Self-checking testbench for the first-fit region allocator: shadow region table and driver.
`timescale 1ns / 100ps

module tb_first_fit_region_allocator
  import ffra_pkg::*;
();

  // Allow several times the slowest legal run: every word waits out the longest
  // sender gap plus its own pass through the block itself.
  localparam int CYCLE_LIMIT = 100000;
  // Cycles to wait after the last result in case a stray strobe follows.
  localparam int TAIL_CYCLES = 8;
  localparam int RANDOM_WORDS = 1100;
  localparam int REPORT_LIMIT = 10;

  // The region end is clipped to the top of the address space.
  localparam logic [ADDR_W:0] SPAN_TOP = {1'b1, {ADDR_W{1'b0}}};

  // One result word as the allocator should give it.
  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] granted;
  } grant_word_t;

  // Shadow copy of the free-region table; predicts the result of every accepted
  // word and matches it against what the block shows.
  class region_table_shadow;
    logic [ADDR_W-1:0] hdr_q  [MAX_REGIONS];
    logic [ADDR_W-1:0] size_q [MAX_REGIONS];
    int unsigned       live_count;
    grant_word_t       pending_grants [$];
    int unsigned       mismatch_count;

    function new();
      live_count     = 0;
      mismatch_count = 0;
    endfunction

    function void note_word(logic act, logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] len,
                            logic [2:0] rtype, logic [ADDR_W-1:0] req);
      grant_word_t       w;
      logic [ADDR_W:0]   span_end;
      logic [ADDR_W:0]   hdr;
      logic [ADDR_W-1:0] sz;
      int                fit;
      w = '0;
      if (act == ACT_ADD) begin
        span_end = {1'b0, base} + {1'b0, len};
        if (span_end > SPAN_TOP) span_end = SPAN_TOP;
        hdr = {1'b0, base} + (ALIGN_BYTES - 1);
        hdr[ALIGN_W-1:0] = '0;
        if (rtype != 3'd0) begin
          w.status = ST_TYPE;
        end else if (hdr + HEADER_BYTES > span_end) begin
          w.status = ST_SMALL;
        end else if (live_count >= MAX_REGIONS) begin
          w.status = ST_FULL;
        end else begin
          for (int i = MAX_REGIONS - 1; i > 0; i--) begin
            if (i <= live_count) begin
              hdr_q[i]  = hdr_q[i-1];
              size_q[i] = size_q[i-1];
            end
          end
          hdr_q[0]  = hdr[ADDR_W-1:0];
          size_q[0] = ADDR_W'(span_end - hdr - HEADER_BYTES);
          live_count++;
          w.status = ST_ADDED;
        end
      end else begin
        fit = -1;
        for (int i = 0; i < MAX_REGIONS; i++) begin
          if (fit < 0 && i < live_count && size_q[i] >= req) fit = i;
        end
        if (fit < 0) begin
          w.status = ST_NOFIT;
        end else begin
          sz       = size_q[fit];
          w.status = ST_ALLOC;
          w.addr   = hdr_q[fit] + HEADER_BYTES;
          if (sz - req >= HEADER_BYTES) begin
            // split in place: the remainder keeps the slot
            hdr_q[fit]  = hdr_q[fit] + HEADER_BYTES + req;
            size_q[fit] = sz - req - HEADER_BYTES;
            w.granted   = req;
          end else begin
            // whole region goes: close the gap from the hit onwards
            for (int j = 0; j < MAX_REGIONS - 1; j++) begin
              if (j >= fit && j + 1 < live_count) begin
                hdr_q[j]  = hdr_q[j+1];
                size_q[j] = size_q[j+1];
              end
            end
            live_count--;
            w.granted = sz;
          end
        end
      end
      pending_grants.push_back(w);
    endfunction

    function void check_result(grant_word_t got);
      grant_word_t want;
      if (pending_grants.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result word: status %0d address %h granted %h",
                   got.status, got.addr, got.granted);
        return;
      end
      want = pending_grants.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("result mismatch: expected status %0d address %h granted %h,",
                   want.status, want.addr, want.granted,
                   " got status %0d address %h granted %h",
                   got.status, got.addr, got.granted);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_action;
  logic [ADDR_W-1:0] in_region_base;
  logic [ADDR_W-1:0] in_region_length;
  logic [2:0]        in_region_type;
  logic [ADDR_W-1:0] in_request_size;
  logic              out_valid;
  logic [2:0]        out_status;
  logic [ADDR_W-1:0] out_address;
  logic [ADDR_W-1:0] out_granted_size;

  region_table_shadow sb;
  int                 sender_idle_pct;
  int                 cycle_count;

  first_fit_region_allocator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_region_base   (in_region_base),
    .in_region_length (in_region_length),
    .in_region_type   (in_region_type),
    .in_request_size  (in_request_size),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_address      (out_address),
    .out_granted_size (out_granted_size)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // Sample both channels at the rising edge. A result is shown for one cycle
  // only, so check it before noting the word taken at the same edge; the
  // strobed result always belongs to an older word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result(grant_word_t'{out_status, out_address, out_granted_size});
      if (start && !busy)
        sb.note_word(in_action, in_region_base, in_region_length, in_region_type,
                     in_request_size);
    end
  end

  // Hold one word on the input ports from a falling edge until it is taken.
  // busy only moves at a rising edge, so its value at the falling edge is the
  // one the next rising edge sees. Drop start afterwards only when idling.
  task automatic send_word(input logic act, input logic [ADDR_W-1:0] base,
                           input logic [ADDR_W-1:0] len, input logic [2:0] rtype,
                           input logic [ADDR_W-1:0] req);
    bit taken;
    int gap;
    start            <= 1'b1;
    in_action        <= act;
    in_region_base   <= base;
    in_region_length <= len;
    in_region_type   <= rtype;
    in_request_size  <= req;
    do begin
      taken = !busy;
      @(negedge clk);
    end while (!taken);
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Mostly well-formed traffic: usable regions of modest size and requests
  // aimed just around the size of a live region, so splits, removals and
  // no-fits all come up. The rest is full-width noise and odd types.
  task automatic random_word();
    logic              act;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
    logic [ADDR_W-1:0] req;
    logic [2:0]        rtype;
    int                pick;
    int                k;
    base  = rand_addr();
    len   = rand_addr();
    req   = rand_addr();
    rtype = 3'($urandom);
    act   = ($urandom_range(99) < 45) ? ACT_ADD : ACT_ALLOC;
    if (act == ACT_ADD) begin
      rtype = ($urandom_range(99) < 85) ? 3'd0 : 3'($urandom_range(1, 7));
      case ($urandom_range(9))
        0: begin
          // full-width base and length: end clipping at the top
        end
        1: begin
          base = {ADDR_W{1'b1}} - $urandom_range(0, 200);
          len  = ADDR_W'($urandom_range(0, 400));
        end
        2, 3: begin
          base = ADDR_W'($urandom_range(0, 'hffff));
          len  = ADDR_W'($urandom_range(0, 48));
        end
        default: begin
          base = ADDR_W'($urandom);
          len  = ADDR_W'($urandom_range(0, 'h10000));
        end
      endcase
    end else begin
      case ($urandom_range(9))
        0: begin
          // full-width request: almost always no fit
        end
        1: req = ADDR_W'($urandom_range(0, 32));
        default: begin
          if (sb.live_count > 0) begin
            pick = $urandom_range(0, sb.live_count - 1);
            k    = $urandom_range(0, 40);
            req  = sb.size_q[pick] + 2 - k;
          end else begin
            req = ADDR_W'($urandom_range(0, 4096));
          end
        end
      endcase
    end
    send_word(act, base, len, rtype, req);
  endtask

  // Cycle counter: end the run if it hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_first_fit_region_allocator failed");
    $finish;
  end

  initial begin
    sb               = new();
    sender_idle_pct  = 24;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_action        = ACT_ADD;
    in_region_base   = '0;
    in_region_length = '0;
    in_region_type   = 3'd0;
    in_request_size  = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words. Empty table: no fit, even for a zero request.
    send_word(ACT_ALLOC, rand_addr(), rand_addr(), 3'($urandom), '0);
    // Non-usable type wins over every other check.
    send_word(ACT_ADD, '0, '0, 3'd7, rand_addr());
    // Too small once aligned up and the header taken off.
    send_word(ACT_ADD, 52'd1, 52'd30, 3'd0, rand_addr());
    // Top of the address space: aligned header lands on the clipped end.
    send_word(ACT_ADD, {ADDR_W{1'b1}}, {ADDR_W{1'b1}}, 3'd0, rand_addr());
    // Clipped end still leaves eight payload bytes.
    send_word(ACT_ADD, {ADDR_W{1'b1}} - 31, {ADDR_W{1'b1}}, 3'd0, rand_addr());
    // Exactly zero payload bytes is still added, at the head.
    send_word(ACT_ADD, '0, 52'd24, 3'd0, rand_addr());
    // Zero request takes the head entry whole.
    send_word(ACT_ALLOC, rand_addr(), rand_addr(), 3'($urandom), '0);
    // Largest request fits nowhere.
    send_word(ACT_ALLOC, rand_addr(), rand_addr(), 3'($urandom), {ADDR_W{1'b1}});
    // Fill the table, then offer one more region.
    for (int i = 0; i < MAX_REGIONS - 1; i++)
      send_word(ACT_ADD, ADDR_W'(52'h1000 * (i + 1) + i), ADDR_W'(52'h200 + 40 * i), 3'd0,
                rand_addr());
    send_word(ACT_ADD, 52'h80000, 52'h1000, 3'd0, rand_addr());

    // Random words in three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 53 : 0;
      for (int n = 0; n < RANDOM_WORDS / 3; n++)
        random_word();
    end
    start <= 1'b0;

    // Drain: wait for every expected result, then a few cycles for strays.
    while (sb.pending_grants.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.mismatch_count == 0) begin
      $display("tb_first_fit_region_allocator passed");
    end else begin
      $display("tb_first_fit_region_allocator failed");
    end
    $finish;
  end

endmodule
